// ===== design/const_accel_kalman_1d_top_defines.svh =====
// assertion macros for the constant-acceleration tracker checker
`ifndef CONST_ACCEL_KALMAN_1D_TOP_DEFINES_SVH
`define CONST_ACCEL_KALMAN_1D_TOP_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define CAK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CAK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/cak_pkg.sv =====
// shared types, constants and the micro-program of the tracker
`default_nettype none
package cak_pkg;

  // default number format
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // port widths fixed by the item fields
  localparam int FIELD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 3'd3;

  // item operations
  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  // working store map
  localparam int MEM_DEPTH = 19;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int A_X0      = 0;
  localparam int A_P0      = 3;
  localparam int A_K0      = 12;
  localparam int A_INNOV   = 15;
  localparam int A_HALF    = 16;
  localparam int A_TMP     = 17;
  localparam int A_DEN     = 18;
  localparam int INIT_LEN  = 12;

  // micro-program layout
  localparam int PRED_LEN = 46;
  localparam int PROG_LEN = 75;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_ADDF, ALU_MUL, ALU_MULH, ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {SRC_A_MEM, SRC_A_Z, SRC_A_TS} src_a_t;
  typedef enum logic [1:0] {SRC_B_MEM, SRC_B_TS, SRC_B_Q, SRC_B_R} src_b_t;

  typedef struct packed {
    alu_op_t op;
    src_a_t  asel;
    addr_t   aa;
    src_b_t  bsel;
    addr_t   ba;
    addr_t   dst;
    logic    last;
  } uop_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_FETCH, S_LOAD, S_RUN, S_FIN1, S_FIN2
  } top_state_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_ROUND, A_SAT, A_DONE
  } alu_state_t;

  function automatic uop_t mk(input alu_op_t op, input src_a_t asel, input int aa,
                              input src_b_t bsel, input int ba, input int dst);
    uop_t u;
    u.op   = op;
    u.asel = asel;
    u.aa   = addr_t'(aa);
    u.bsel = bsel;
    u.ba   = addr_t'(ba);
    u.dst  = addr_t'(dst);
    u.last = 1'b0;
    return u;
  endfunction

  // predict: half step, F applied to x, to columns then rows of P, noise on diagonal
  // update: gain, innovation, state correction, covariance rows 1, 2 then 0
  function automatic uop_t prog(input logic [PC_W-1:0] pc);
    uop_t t [PROG_LEN];
    int   n;
    int   v;
    int   i;
    int   j;
    int   r;
    int   v0;
    int   v1;
    int   v2;
    n = 0;
    t[n] = mk(ALU_MULH, SRC_A_TS, 0, SRC_B_TS, 0, A_HALF); n++;
    for (v = 0; v < 7; v++) begin
      if (v == 0) begin
        v0 = A_X0; v1 = A_X0 + 1; v2 = A_X0 + 2;
      end else if (v < 4) begin
        v0 = A_P0 + v - 1; v1 = A_P0 + v + 2; v2 = A_P0 + v + 5;
      end else begin
        v0 = A_P0 + 3 * (v - 4); v1 = v0 + 1; v2 = v0 + 2;
      end
      t[n] = mk(ALU_MUL, SRC_A_TS, 0, SRC_B_MEM, v1, A_TMP); n++;
      t[n] = mk(ALU_ADD, SRC_A_MEM, v0, SRC_B_MEM, A_TMP, v0); n++;
      t[n] = mk(ALU_MUL, SRC_A_MEM, A_HALF, SRC_B_MEM, v2, A_TMP); n++;
      t[n] = mk(ALU_ADD, SRC_A_MEM, v0, SRC_B_MEM, A_TMP, v0); n++;
      t[n] = mk(ALU_MUL, SRC_A_TS, 0, SRC_B_MEM, v2, A_TMP); n++;
      t[n] = mk(ALU_ADD, SRC_A_MEM, v1, SRC_B_MEM, A_TMP, v1); n++;
    end
    for (i = 0; i < 3; i++) begin
      t[n] = mk(ALU_ADD, SRC_A_MEM, A_P0 + 4 * i, SRC_B_Q, 0, A_P0 + 4 * i); n++;
    end
    t[PRED_LEN-1].last = 1'b1;
    t[n] = mk(ALU_ADDF, SRC_A_MEM, A_P0, SRC_B_R, 0, A_DEN); n++;
    for (i = 0; i < 3; i++) begin
      t[n] = mk(ALU_DIV, SRC_A_MEM, A_P0 + 3 * i, SRC_B_MEM, A_DEN, A_K0 + i); n++;
    end
    t[n] = mk(ALU_SUB, SRC_A_Z, 0, SRC_B_MEM, A_X0, A_INNOV); n++;
    for (i = 0; i < 3; i++) begin
      t[n] = mk(ALU_MUL, SRC_A_MEM, A_K0 + i, SRC_B_MEM, A_INNOV, A_TMP); n++;
      t[n] = mk(ALU_ADD, SRC_A_MEM, A_X0 + i, SRC_B_MEM, A_TMP, A_X0 + i); n++;
    end
    for (i = 0; i < 3; i++) begin
      r = (i == 2) ? 0 : i + 1;
      for (j = 0; j < 3; j++) begin
        t[n] = mk(ALU_MUL, SRC_A_MEM, A_K0 + r, SRC_B_MEM, A_P0 + j, A_TMP); n++;
        t[n] = mk(ALU_SUB, SRC_A_MEM, A_P0 + 3 * r + j, SRC_B_MEM, A_TMP,
                  A_P0 + 3 * r + j); n++;
      end
    end
    t[PROG_LEN-1].last = 1'b1;
    if (int'(pc) < PROG_LEN) return t[pc];
    return mk(ALU_ADD, SRC_A_MEM, 0, SRC_B_MEM, 0, A_TMP);
  endfunction

endpackage
`default_nettype wire

// ===== design/cak_ifs.sv =====
// item channel interfaces: command in, estimate out
`default_nettype none
interface cak_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [cak_pkg::FIELD_W-1:0] measured_position;
  modport source (output valid, operation, measured_position, input ready);
  modport sink (input valid, operation, measured_position, output ready);
endinterface

interface cak_est_if;
  logic                             valid;
  logic                             ready;
  logic signed [cak_pkg::FIELD_W-1:0] est_position;
  logic signed [cak_pkg::FIELD_W-1:0] est_velocity;
  modport source (output valid, est_position, est_velocity, input ready);
  modport sink (input valid, est_position, est_velocity, output ready);
endinterface
`default_nettype wire

// ===== design/cak_alu.sv =====
// shared saturating unit: add (also with a floor at one), subtract, serial multiply with rounding, serial divide
`default_nettype none
module cak_alu #(
  parameter int WORD_BITS = cak_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cak_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cak_pkg::alu_req_t    req,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] result
);
  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int MW   = (2 * W > W + F) ? 2 * W : W + F;
  localparam int CNTW = $clog2(W + F);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  cak_pkg::alu_state_t state, state_next;
  cak_pkg::alu_op_t    op;
  logic                neg;
  logic [W-1:0]        mplr;
  logic [W-1:0]        mb;
  logic [W+F-1:0]      dvd;
  logic [W-1:0]        rem;
  logic [MW-1:0]       prod;
  logic [CNTW-1:0]     cnt;

  logic [W-1:0]  ma, mbs;
  logic [W:0]    sum;
  logic [W-1:0]  sat_sum;
  logic [W:0]    trial;
  logic          ge;
  logic [MW-1:0] rounded;
  logic          over;

  // magnitudes of the operands
  assign ma  = a[W-1] ? (~a + W'(1)) : a;
  assign mbs = b[W-1] ? (~b + W'(1)) : b;

  // saturating add or subtract
  always_comb begin
    if (req.op == cak_pkg::ALU_SUB) sum = {a[W-1], a} - {b[W-1], b};
    else sum = {a[W-1], a} + {b[W-1], b};
    if (sum[W] != sum[W-1]) sat_sum = sum[W] ? WMIN : WMAX;
    else sat_sum = sum[W-1:0];
    if (req.op == cak_pkg::ALU_ADDF && (sat_sum[W-1] || sat_sum == '0)) sat_sum = W'(1);
  end

  // one restoring divide step
  assign trial = {rem, dvd[W+F-1]};
  assign ge    = trial >= {1'b0, mb};

  // rounding to nearest, ties away from zero
  always_comb begin
    if (op == cak_pkg::ALU_MULH) rounded = (prod + (MW'(1) << F)) >> (F + 1);
    else rounded = (prod + (MW'(1) << (F - 1))) >> F;
  end

  assign over = |prod[MW-1:W-1];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cak_pkg::A_IDLE: begin
        if (req.start) begin
          case (req.op)
            cak_pkg::ALU_MUL, cak_pkg::ALU_MULH: state_next = cak_pkg::A_MUL;
            cak_pkg::ALU_DIV: state_next = cak_pkg::A_DIV;
            default: state_next = cak_pkg::A_DONE;
          endcase
        end
      end
      cak_pkg::A_MUL:   if (cnt == '0) state_next = cak_pkg::A_ROUND;
      cak_pkg::A_DIV:   if (cnt == '0) state_next = cak_pkg::A_SAT;
      cak_pkg::A_ROUND: state_next = cak_pkg::A_SAT;
      cak_pkg::A_SAT:   state_next = cak_pkg::A_DONE;
      cak_pkg::A_DONE:  state_next = cak_pkg::A_IDLE;
      default:          state_next = cak_pkg::A_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state == cak_pkg::A_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cak_pkg::A_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      cak_pkg::A_IDLE: begin
        if (req.start) begin
          op     <= req.op;
          prod   <= '0;
          rem    <= '0;
          result <= sat_sum;
          if (req.op == cak_pkg::ALU_DIV) begin
            neg <= a[W-1];
            dvd <= {ma, {F{1'b0}}};
            mb  <= b;
            cnt <= CNTW'(W + F - 1);
          end else begin
            neg  <= a[W-1] ^ b[W-1];
            mplr <= ma;
            mb   <= mbs;
            cnt  <= CNTW'(W - 1);
          end
        end
      end
      cak_pkg::A_MUL: begin
        prod <= {prod[MW-2:0], 1'b0} + (mplr[W-1] ? MW'(mb) : '0);
        mplr <= {mplr[W-2:0], 1'b0};
        cnt  <= cnt - CNTW'(1);
      end
      cak_pkg::A_DIV: begin
        rem  <= ge ? W'(trial - {1'b0, mb}) : trial[W-1:0];
        prod <= {prod[MW-2:0], ge};
        dvd  <= {dvd[W+F-2:0], 1'b0};
        cnt  <= cnt - CNTW'(1);
      end
      cak_pkg::A_ROUND: prod <= rounded;
      cak_pkg::A_SAT: begin
        if (neg) result <= over ? WMIN : (~prod[W-1:0] + W'(1));
        else result <= over ? WMAX : prod[W-1:0];
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/const_accel_kalman_1d_top.sv =====
// constant-acceleration Kalman tracker: sequencer, working store and configuration
// One item at a time runs through a micro-program on a single shared unit (cak_alu).
// Each operation passes through a fetch state and a load state that starts the unit;
// the unit adds or subtracts directly and multiplies or divides serially on words of
// the 32/16 default format. A predict item is 22 multiplies and 24 adds; an update
// item is 12 multiplies, 3 divides and 14 adds. The states S_FIN1 and S_FIN2 move the result
// to the output register, which holds it while the next item is already accepted.
// After reset and after any start_position write a loading pass fills the state
// and covariance store; no item is accepted during that pass.
`default_nettype none
module const_accel_kalman_1d_top #(
  parameter int WORD_BITS = cak_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cak_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  cak_cmd_if.sink                         cmd,
  cak_est_if.source                       est,
  input  logic                            cfg_we,
  input  logic [cak_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cak_pkg::CFG_W-1:0]       cfg_data
);
  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int CW = (W > 32) ? W : 32;
  localparam int IW = $clog2(cak_pkg::INIT_LEN);
  localparam int PW = cak_pkg::PC_W;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] TEN  = (W - 1 - F >= 4) ? (W'(10) << F) : WMAX;

  // unsigned register value limited to the word range
  function automatic logic [W-1:0] sat_u31(input logic [cak_pkg::CFG_W-1:0] v);
    logic [CW:0] u;
    u = (CW+1)'(v[30:0]);
    if (u > {{(CW+1-W){1'b0}}, WMAX}) return WMAX;
    return u[W-1:0];
  endfunction

  // signed 32-bit value limited to the word range
  function automatic logic [W-1:0] sat_s32(input logic [31:0] v);
    logic signed [CW:0] s;
    logic signed [CW:0] hi;
    logic signed [CW:0] lo;
    s  = {{(CW+1-32){v[31]}}, v};
    hi = {{(CW+1-W){1'b0}}, WMAX};
    lo = {{(CW+1-W){1'b1}}, WMIN};
    if (s > hi) return WMAX;
    if (s < lo) return WMIN;
    return s[W-1:0];
  endfunction

  // word limited to 32 bits for the result
  function automatic logic [31:0] sat_out(input logic [W-1:0] v);
    logic signed [CW:0] s;
    logic signed [CW:0] hi;
    logic signed [CW:0] lo;
    s  = {{(CW+1-W){v[W-1]}}, v};
    hi = {{(CW+1-32){1'b0}}, 32'h7fff_ffff};
    lo = {{(CW+1-32){1'b1}}, 32'h8000_0000};
    if (s > hi) return 32'h7fff_ffff;
    if (s < lo) return 32'h8000_0000;
    return s[31:0];
  endfunction

  cak_pkg::top_state_t state, state_next;
  logic [W-1:0]  ts, q, r, sp, z;
  logic [IW-1:0] init_cnt;
  logic [PW-1:0] pc;
  logic [31:0]   pos_r, vel_r;
  logic          est_valid_r;

  logic [W-1:0]  mem [cak_pkg::MEM_DEPTH];
  logic [W-1:0]  rd_a, rd_b;

  cak_pkg::uop_t    uop;
  cak_pkg::alu_req_t alu_req;
  cak_pkg::addr_t   ra, rb, wa;
  logic [W-1:0]     wd, opa, opb, alu_res;
  logic             we, alu_done, pc_inc, load_out, cmd_take, restart;

  assign uop      = cak_pkg::prog(pc);
  assign cmd_take = cmd.valid && cmd.ready;
  assign restart  = cfg_we && (cfg_index == cak_pkg::CFG_START_POSITION);

  cak_alu #(.WORD_BITS(W), .FRAC_BITS(F)) u_alu (
    .clk(clk), .rst(rst), .req(alu_req), .a(opa), .b(opb),
    .done(alu_done), .result(alu_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cak_pkg::S_INIT: if (init_cnt == IW'(cak_pkg::INIT_LEN - 1)) state_next = cak_pkg::S_IDLE;
      cak_pkg::S_IDLE:  if (cmd_take) state_next = cak_pkg::S_FETCH;
      cak_pkg::S_FETCH: state_next = cak_pkg::S_LOAD;
      cak_pkg::S_LOAD:  state_next = cak_pkg::S_RUN;
      cak_pkg::S_RUN: begin
        if (alu_done) state_next = uop.last ? cak_pkg::S_FIN1 : cak_pkg::S_FETCH;
      end
      cak_pkg::S_FIN1:  state_next = cak_pkg::S_FIN2;
      cak_pkg::S_FIN2:  if (!est_valid_r || est.ready) state_next = cak_pkg::S_IDLE;
      default:          state_next = cak_pkg::S_INIT;
    endcase
    if (restart) state_next = cak_pkg::S_INIT;
  end

  // outputs of the sequencer
  always_comb begin
    cmd.ready     = (state == cak_pkg::S_IDLE);
    we            = 1'b0;
    wa            = cak_pkg::addr_t'(init_cnt);
    wd            = '0;
    ra            = uop.aa;
    rb            = uop.ba;
    alu_req.start = 1'b0;
    alu_req.op    = uop.op;
    pc_inc        = 1'b0;
    load_out      = 1'b0;
    case (uop.asel)
      cak_pkg::SRC_A_Z:  opa = z;
      cak_pkg::SRC_A_TS: opa = ts;
      default:           opa = rd_a;
    endcase
    case (uop.bsel)
      cak_pkg::SRC_B_TS: opb = ts;
      cak_pkg::SRC_B_Q:  opb = q;
      cak_pkg::SRC_B_R:  opb = r;
      default:           opb = rd_b;
    endcase
    case (state)
      cak_pkg::S_INIT: begin
        we = 1'b1;
        if (int'(init_cnt) == cak_pkg::A_X0) wd = sp;
        else if (int'(init_cnt) == cak_pkg::A_P0 || int'(init_cnt) == cak_pkg::A_P0 + 4 ||
                 int'(init_cnt) == cak_pkg::A_P0 + 8) wd = TEN;
      end
      cak_pkg::S_LOAD: alu_req.start = 1'b1;
      cak_pkg::S_RUN: begin
        if (alu_done) begin
          we     = 1'b1;
          wa     = uop.dst;
          wd     = alu_res;
          pc_inc = !uop.last;
        end
      end
      cak_pkg::S_FIN1, cak_pkg::S_FIN2: begin
        ra       = cak_pkg::addr_t'(cak_pkg::A_X0);
        rb       = cak_pkg::addr_t'(cak_pkg::A_X0 + 1);
        load_out = (state == cak_pkg::S_FIN2) && (!est_valid_r || est.ready);
      end
      default: ;
    endcase
  end

  // working store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cak_pkg::S_INIT;
      init_cnt    <= '0;
      pc          <= '0;
      est_valid_r <= 1'b0;
      ts          <= W'(2185);
      q           <= W'(655);
      r           <= W'(65536);
      sp          <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          cak_pkg::CFG_TIME_STEP: begin
            ts <= (sat_u31(cfg_data) == '0) ? W'(1) : sat_u31(cfg_data);
          end
          cak_pkg::CFG_PROCESS_NOISE:  q  <= sat_u31(cfg_data);
          cak_pkg::CFG_MEASURE_NOISE:  r  <= sat_u31(cfg_data);
          cak_pkg::CFG_START_POSITION: sp <= sat_s32(cfg_data);
          default: ;
        endcase
      end
      if (restart) init_cnt <= '0;
      else if (state == cak_pkg::S_INIT) init_cnt <= init_cnt + IW'(1);
      if (cmd_take) begin
        pc <= (cmd.operation == cak_pkg::OP_UPDATE) ? PW'(cak_pkg::PRED_LEN) : '0;
      end else if (pc_inc) begin
        pc <= pc + PW'(1);
      end
      if (load_out) est_valid_r <= 1'b1;
      else if (est.ready) est_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_take) z <= sat_s32(cmd.measured_position);
    if (load_out) begin
      pos_r <= sat_out(rd_a);
      vel_r <= sat_out(rd_b);
    end
  end

  assign est.valid        = est_valid_r;
  assign est.est_position = pos_r;
  assign est.est_velocity = vel_r;
endmodule
`default_nettype wire

// ===== design/cak_checker.sv =====
// port-level checks on the tracker, bound to the top level
`default_nettype none
`include "const_accel_kalman_1d_top_defines.svh"
module cak_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          est_valid,
  input logic                          est_ready,
  input logic [cak_pkg::FIELD_W-1:0]   est_position,
  input logic [cak_pkg::FIELD_W-1:0]   est_velocity,
  input logic                          cfg_we,
  input logic [cak_pkg::CFG_IDX_W-1:0] cfg_index
);
  // one item at a time: busy right after taking an item
  `CAK_ASSERT_NEXT(a_busy_after_item, cmd_valid && cmd_ready, !cmd_ready, "ready after item")
  // a start position write starts the loading pass
  `CAK_ASSERT_NEXT(a_load_on_restart, cfg_we && cfg_index == cak_pkg::CFG_START_POSITION, !cmd_ready, "ready during load pass")
  // a new result only comes out of a busy phase
  `CAK_ASSERT_NOW(a_result_from_work, $rose(est_valid), !$past(cmd_ready), "result without work")
  // stalled result holds
  `CAK_ASSERT_NEXT(a_hold_stalled, est_valid && !est_ready, est_valid && $stable(est_position) && $stable(est_velocity), "stalled result changed")
endmodule

bind const_accel_kalman_1d_top cak_checker u_cak_checker (
  .clk(clk), .rst(rst),
  .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .est_valid(est.valid), .est_ready(est.ready),
  .est_position(est.est_position), .est_velocity(est.est_velocity),
  .cfg_we(cfg_we), .cfg_index(cfg_index)
);
`default_nettype wire
